// ===== rtl/core/flc_pkg.sv =====
// Package for the FDTD lossy coefficient unit: float types, constants, latencies
// and the unpack / round / pack helpers of the single-precision pipeline.
// Depends on nothing; used by the interfaces, flc_fpu and the top level.
package flc_pkg;

  localparam int FLT_W     = 32;
  localparam int CFG_IDX_W = 4;
  localparam int DIV_STEPS = 25;

  localparam int L_MUL = 5;
  localparam int L_ADD = 7;
  localparam int L_DIV = DIV_STEPS + 4;
  localparam int LAT   = L_MUL + 2 * L_DIV + L_ADD;

  typedef logic [FLT_W-1:0]  word_t;
  typedef logic signed [10:0] exp_t;

  localparam word_t FP_ONE    = 32'h3F80_0000;
  localparam word_t FP_TWO    = 32'h4000_0000;
  localparam word_t CANON_NAN = 32'h7FC0_0000;

  localparam exp_t EXP_BIAS   = 11'sd127;
  localparam exp_t EXP_ZERO   = -11'sd256;
  localparam exp_t EXP_INF    = 11'sd255;
  localparam exp_t EXP_DN_MIN = -11'sd25;
  localparam exp_t EXP_ONE    = 11'sd1;

  typedef enum logic [1:0] {FOP_MUL, FOP_ADD, FOP_DIV} fop_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP = 4'd0,
    REG_CELL_SIZE = 4'd1
  } cfg_reg_t;

  // normalized operand: man[23] set unless zero
  typedef struct packed {
    logic        sgn;
    exp_t        ex;
    logic [23:0] man;
    logic        nan;
    logic        inf;
    logic        zero;
  } unp_t;

  // before rounding: man[25] hidden, [24:2] fraction, [1] guard, [0] sticky
  typedef struct packed {
    logic        sgn;
    exp_t        ex;
    logic [25:0] man;
    logic        nan;
    logic        inf;
    logic        zero;
  } pre_t;

  typedef struct packed {
    logic        sgn;
    logic [7:0]  efld;
    logic [25:0] man;
    logic        ovf;
    logic        nan;
    logic        inf;
    logic        zero;
  } rnd_t;

  typedef struct packed {
    logic        sgn;
    exp_t        ex;
    logic [23:0] dvs;
    logic [25:0] rem;
    logic [24:0] quo;
    logic        nan;
    logic        inf;
    logic        zero;
  } dst_t;

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd0;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  function automatic unp_t unpack(input word_t w);
    unp_t       u;
    logic [4:0] lz;
    lz     = lzc27({w[22:0], 4'hF});
    u.sgn  = w[31];
    u.nan  = (&w[30:23]) && (|w[22:0]);
    u.inf  = (&w[30:23]) && !(|w[22:0]);
    u.zero = ~(|w[30:0]);
    if (w[30:23] != 8'd0) begin
      u.ex  = exp_t'({3'b000, w[30:23]});
      u.man = {1'b1, w[22:0]};
    end else if (u.zero) begin
      u.ex  = EXP_ZERO;
      u.man = 24'd0;
    end else begin
      u.ex  = exp_t'(0) - exp_t'({6'd0, lz});
      u.man = {1'b0, w[22:0]} << (lz + 5'd1);
    end
    return u;
  endfunction

  function automatic dst_t div_step(input dst_t s);
    dst_t        t;
    logic [25:0] dif;
    t   = s;
    dif = s.rem - {2'b00, s.dvs};
    if (s.rem >= {2'b00, s.dvs}) begin
      t.quo = {s.quo[23:0], 1'b1};
      t.rem = {dif[24:0], 1'b0};
    end else begin
      t.quo = {s.quo[23:0], 1'b0};
      t.rem = {s.rem[24:0], 1'b0};
    end
    return t;
  endfunction

  // shift subnormal results into place, collecting sticky
  function automatic rnd_t denorm(input pre_t p);
    rnd_t        r;
    logic [4:0]  sh;
    logic [25:0] ms;
    logic        lost;
    r.sgn  = p.sgn;
    r.nan  = p.nan;
    r.inf  = p.inf;
    r.zero = p.zero;
    r.ovf  = (p.ex >= EXP_INF);
    sh     = 5'd0;
    ms     = p.man;
    lost   = 1'b0;
    if (p.ex < EXP_ONE) begin
      sh     = (p.ex < EXP_DN_MIN) ? 5'd26 : 5'(EXP_ONE - p.ex);
      ms     = p.man >> sh;
      lost   = |(p.man & ~(26'h3FF_FFFF << sh));
      r.efld = 8'd0;
      r.man  = {ms[25:1], ms[0] | lost};
    end else begin
      r.efld = p.ex[7:0];
      r.man  = p.man;
    end
    return r;
  endfunction

  // round to nearest even; carry may run into the exponent or to infinity
  function automatic word_t pack(input rnd_t r);
    logic        inc;
    logic [30:0] body;
    word_t       w;
    inc  = r.man[1] & (r.man[0] | r.man[2]);
    body = {r.efld, r.man[24:2]} + {30'd0, inc};
    if (r.nan) w = CANON_NAN;
    else if (r.inf || r.ovf) w = {r.sgn, 8'hFF, 23'd0};
    else if (r.zero) w = {r.sgn, 31'd0};
    else w = {r.sgn, body};
    return w;
  endfunction

endpackage

// ===== rtl/core/flc_cell_if.sv =====
// Input channel of the FDTD lossy coefficient unit: one cell's material values.
// Depends on flc_pkg.
interface flc_cell_if;
  logic             valid;
  logic             ready;
  flc_pkg::word_t   permeability;
  flc_pkg::word_t   permittivity;
  flc_pkg::word_t   magnetic_conductivity;
  flc_pkg::word_t   electric_conductivity;
  logic             last_cell;

  modport source (output valid, permeability, permittivity, magnetic_conductivity,
                  electric_conductivity, last_cell, input ready);
  modport sink (input valid, permeability, permittivity, magnetic_conductivity,
                electric_conductivity, last_cell, output ready);
endinterface

// ===== rtl/core/flc_coef_if.sv =====
// Result channel of the FDTD lossy coefficient unit: four coefficients per cell.
// Depends on flc_pkg.
interface flc_coef_if;
  logic           valid;
  logic           ready;
  flc_pkg::word_t h_decay;
  flc_pkg::word_t h_curl_gain;
  flc_pkg::word_t e_decay;
  flc_pkg::word_t e_curl_gain;
  logic           last_result;

  modport source (output valid, h_decay, h_curl_gain, e_decay, e_curl_gain,
                  last_result, input ready);
  modport sink (input valid, h_decay, h_curl_gain, e_decay, e_curl_gain,
                last_result, output ready);
endinterface

// ===== rtl/core/flc_cfg_if.sv =====
// Register write channel of the FDTD lossy coefficient unit.
// Depends on flc_pkg.
interface flc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [flc_pkg::CFG_IDX_W-1:0]   index;
  flc_pkg::word_t                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/flc_fpu.sv =====
// Pipelined single-precision operator (multiply, add or divide), RNE, subnormals.
// Fixed latency per operator from flc_pkg; no stall, no reset. Depends on flc_pkg.
module flc_fpu #(
  parameter flc_pkg::fop_t OP = flc_pkg::FOP_MUL
) (
  input  logic           clk,
  input  flc_pkg::word_t a,
  input  flc_pkg::word_t b,
  output flc_pkg::word_t y
);

  flc_pkg::unp_t  ua_r, ub_r;
  flc_pkg::pre_t  pre_w;
  flc_pkg::rnd_t  rnd_r;
  flc_pkg::word_t y_r;

  always_ff @(posedge clk) begin
    ua_r  <= flc_pkg::unpack(a);
    ub_r  <= flc_pkg::unpack(b);
    rnd_r <= flc_pkg::denorm(pre_w);
    y_r   <= flc_pkg::pack(rnd_r);
  end

  assign y = y_r;

  generate
    if (OP == flc_pkg::FOP_MUL) begin : g_mul
      typedef struct packed {
        logic          sgn;
        flc_pkg::exp_t ex;
        logic [47:0]   prod;
        logic          nan;
        logic          inf;
        logic          zero;
      } mul_t;

      mul_t          m_r;
      flc_pkg::pre_t pre_r, pre_nxt;

      always_comb begin
        pre_nxt.sgn  = m_r.sgn;
        pre_nxt.nan  = m_r.nan;
        pre_nxt.inf  = m_r.inf;
        pre_nxt.zero = m_r.zero;
        if (m_r.prod[47]) begin
          pre_nxt.ex  = m_r.ex + flc_pkg::EXP_ONE;
          pre_nxt.man = {m_r.prod[47:23], |m_r.prod[22:0]};
        end else begin
          pre_nxt.ex  = m_r.ex;
          pre_nxt.man = {m_r.prod[46:22], |m_r.prod[21:0]};
        end
      end

      always_ff @(posedge clk) begin
        m_r.sgn  <= ua_r.sgn ^ ub_r.sgn;
        m_r.ex   <= ua_r.ex + ub_r.ex - flc_pkg::EXP_BIAS;
        m_r.prod <= {24'd0, ua_r.man} * {24'd0, ub_r.man};
        m_r.nan  <= ua_r.nan | ub_r.nan | (ua_r.inf & ub_r.zero) | (ua_r.zero & ub_r.inf);
        m_r.inf  <= ua_r.inf | ub_r.inf;
        m_r.zero <= ua_r.zero | ub_r.zero;
        pre_r    <= pre_nxt;
      end

      assign pre_w = pre_r;

    end else if (OP == flc_pkg::FOP_ADD) begin : g_add
      typedef struct packed {
        logic          sgn;
        flc_pkg::exp_t ex;
        logic [23:0]   man_big;
        logic [23:0]   man_sml;
        logic [4:0]    sh;
        logic          sub;
        logic          zsgn;
        logic          isgn;
        logic          nan;
        logic          inf;
      } add1_t;

      typedef struct packed {
        logic          sgn;
        flc_pkg::exp_t ex;
        logic [26:0]   ext_big;
        logic [26:0]   al;
        logic          sub;
        logic          zsgn;
        logic          isgn;
        logic          nan;
        logic          inf;
      } add2_t;

      typedef struct packed {
        logic          sgn;
        flc_pkg::exp_t ex;
        logic [27:0]   sum;
        logic          zsgn;
        logic          isgn;
        logic          nan;
        logic          inf;
      } add3_t;

      add1_t         s1_r, s1_nxt;
      add2_t         s2_r, s2_nxt;
      add3_t         s3_r, s3_nxt;
      flc_pkg::pre_t pre_r, pre_nxt;

      always_comb begin
        logic          a_big;
        flc_pkg::exp_t dif;
        a_big = (ua_r.ex > ub_r.ex) || ((ua_r.ex == ub_r.ex) && (ua_r.man >= ub_r.man));
        dif   = a_big ? (ua_r.ex - ub_r.ex) : (ub_r.ex - ua_r.ex);
        s1_nxt.sgn     = a_big ? ua_r.sgn : ub_r.sgn;
        s1_nxt.ex      = a_big ? ua_r.ex : ub_r.ex;
        s1_nxt.man_big = a_big ? ua_r.man : ub_r.man;
        s1_nxt.man_sml = a_big ? ub_r.man : ua_r.man;
        s1_nxt.sh      = (dif > 11'sd27) ? 5'd27 : dif[4:0];
        s1_nxt.sub     = ua_r.sgn ^ ub_r.sgn;
        s1_nxt.zsgn    = ua_r.sgn & ub_r.sgn;
        s1_nxt.isgn    = ua_r.inf ? ua_r.sgn : ub_r.sgn;
        s1_nxt.nan     = ua_r.nan | ub_r.nan | (ua_r.inf & ub_r.inf & (ua_r.sgn ^ ub_r.sgn));
        s1_nxt.inf     = ua_r.inf | ub_r.inf;
      end

      always_comb begin
        logic [26:0] ext;
        logic [26:0] shd;
        logic        lost;
        ext  = {s1_r.man_sml, 3'b000};
        shd  = ext >> s1_r.sh;
        lost = |(ext & ~(27'h7FF_FFFF << s1_r.sh));
        s2_nxt.sgn     = s1_r.sgn;
        s2_nxt.ex      = s1_r.ex;
        s2_nxt.ext_big = {s1_r.man_big, 3'b000};
        s2_nxt.al      = {shd[26:1], shd[0] | lost};
        s2_nxt.sub     = s1_r.sub;
        s2_nxt.zsgn    = s1_r.zsgn;
        s2_nxt.isgn    = s1_r.isgn;
        s2_nxt.nan     = s1_r.nan;
        s2_nxt.inf     = s1_r.inf;
      end

      always_comb begin
        s3_nxt.sgn  = s2_r.sgn;
        s3_nxt.ex   = s2_r.ex;
        s3_nxt.sum  = s2_r.sub ? ({1'b0, s2_r.ext_big} - {1'b0, s2_r.al})
                               : ({1'b0, s2_r.ext_big} + {1'b0, s2_r.al});
        s3_nxt.zsgn = s2_r.zsgn;
        s3_nxt.isgn = s2_r.isgn;
        s3_nxt.nan  = s2_r.nan;
        s3_nxt.inf  = s2_r.inf;
      end

      always_comb begin
        logic [4:0]  lz;
        logic [26:0] t;
        lz = flc_pkg::lzc27(s3_r.sum[26:0]);
        t  = s3_r.sum[26:0] << lz;
        pre_nxt.nan  = s3_r.nan;
        pre_nxt.inf  = s3_r.inf;
        pre_nxt.zero = (s3_r.sum == 28'd0);
        if (s3_r.inf) pre_nxt.sgn = s3_r.isgn;
        else if (s3_r.sum == 28'd0) pre_nxt.sgn = s3_r.zsgn;
        else pre_nxt.sgn = s3_r.sgn;
        if (s3_r.sum[27]) begin
          pre_nxt.ex  = s3_r.ex + flc_pkg::EXP_ONE;
          pre_nxt.man = {s3_r.sum[27:3], |s3_r.sum[2:0]};
        end else begin
          pre_nxt.ex  = s3_r.ex - flc_pkg::exp_t'({6'd0, lz});
          pre_nxt.man = {t[26:2], |t[1:0]};
        end
      end

      always_ff @(posedge clk) begin
        s1_r  <= s1_nxt;
        s2_r  <= s2_nxt;
        s3_r  <= s3_nxt;
        pre_r <= pre_nxt;
      end

      assign pre_w = pre_r;

    end else begin : g_div
      flc_pkg::dst_t st_r [flc_pkg::DIV_STEPS+1];
      flc_pkg::dst_t st0_nxt;

      always_comb begin
        st0_nxt.sgn  = ua_r.sgn ^ ub_r.sgn;
        st0_nxt.dvs  = ub_r.man;
        st0_nxt.quo  = 25'd0;
        st0_nxt.nan  = ua_r.nan | ub_r.nan | (ua_r.zero & ub_r.zero) | (ua_r.inf & ub_r.inf);
        st0_nxt.inf  = ua_r.inf | ub_r.zero;
        st0_nxt.zero = ua_r.zero | ub_r.inf;
        if (ua_r.man >= ub_r.man) begin
          st0_nxt.rem = {2'b00, ua_r.man};
          st0_nxt.ex  = ua_r.ex - ub_r.ex + flc_pkg::EXP_BIAS;
        end else begin
          st0_nxt.rem = {1'b0, ua_r.man, 1'b0};
          st0_nxt.ex  = ua_r.ex - ub_r.ex + flc_pkg::EXP_BIAS - flc_pkg::EXP_ONE;
        end
      end

      always_ff @(posedge clk) begin
        st_r[0] <= st0_nxt;
        for (int k = 1; k <= flc_pkg::DIV_STEPS; k++) begin
          st_r[k] <= flc_pkg::div_step(st_r[k-1]);
        end
      end

      assign pre_w.sgn  = st_r[flc_pkg::DIV_STEPS].sgn;
      assign pre_w.ex   = st_r[flc_pkg::DIV_STEPS].ex;
      assign pre_w.man  = {st_r[flc_pkg::DIV_STEPS].quo, |st_r[flc_pkg::DIV_STEPS].rem};
      assign pre_w.nan  = st_r[flc_pkg::DIV_STEPS].nan;
      assign pre_w.inf  = st_r[flc_pkg::DIV_STEPS].inf;
      assign pre_w.zero = st_r[flc_pkg::DIV_STEPS].zero;
    end
  endgenerate

endmodule

// ===== rtl/core/fdtd_lossy_coefficient_unit.sv =====
// Top level of the FDTD lossy coefficient unit: input stage, two coefficient
// pipelines of flc_fpu operators, and the output queue. Depends on flc_pkg,
// flc_cell_if, flc_coef_if, flc_cfg_if and flc_fpu.
//
// Usage:
//   in_cell  takes one cell's mu, eps, sigma_m, sigma_e (float32) and a last flag.
//   out_coef returns h_decay, h_curl_gain, e_decay, e_curl_gain and the flag,
//            one item per input item, in order.
//   cfg_wr   writes time_step (index 0) and cell_size (index 1); always ready.
//            Write only while no item is in flight.
// Throughput: one item per cycle while in_cell.ready is high. Path from input
//   to output: input stage, multiply, divide, add, divide, queue read.
// The datapath never stalls; finished items land in a 128-entry queue and
//   in_cell.ready drops once 128 items are accepted but not yet delivered, so
//   a stalled receiver back-pressures the input with nothing lost.
// Reset: time_step = 0.0, cell_size = 1.0, pipeline and queue empty.
module fdtd_lossy_coefficient_unit (
  input  logic            clk,
  input  logic            rst_n,
  flc_cell_if.sink        in_cell,
  flc_coef_if.source      out_coef,
  flc_cfg_if.sink         cfg_wr
);

  localparam int LAT      = flc_pkg::LAT;
  localparam int FIFO_AW  = $clog2(LAT + 2);
  localparam int FIFO_D   = 1 << FIFO_AW;
  localparam int OUT_W    = 4 * flc_pkg::FLT_W + 1;
  localparam logic [FIFO_AW:0] DEPTH_CNT = {1'b1, {FIFO_AW{1'b0}}};

  flc_pkg::word_t dt_r, dx_r;
  flc_pkg::word_t mu_r, eps_r, sm_r, se_r;
  logic [LAT:0]   vld_r;
  logic [LAT:0]   last_r;

  flc_pkg::word_t dec_w  [2];
  flc_pkg::word_t gain_w [2];

  logic [OUT_W-1:0]   fifo_mem [FIFO_D];
  logic [OUT_W-1:0]   out_data_r;
  logic               out_vld_r, out_vld_nxt;
  logic [FIFO_AW:0]   wr_ptr_r, rd_ptr_r, mem_cnt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               in_acc, out_acc, push, pop;

  // registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 32'h0000_0000;
      dx_r <= flc_pkg::FP_ONE;
    end else if (cfg_wr.valid) begin
      unique case (flc_pkg::cfg_reg_t'(cfg_wr.index))
        flc_pkg::REG_TIME_STEP: dt_r <= cfg_wr.data;
        flc_pkg::REG_CELL_SIZE: dx_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // input stage and valid line
  assign in_acc        = in_cell.valid && in_cell.ready;
  assign in_cell.ready = (cnt_r != DEPTH_CNT);

  always_ff @(posedge clk) begin
    mu_r   <= in_cell.permeability;
    eps_r  <= in_cell.permittivity;
    sm_r   <= in_cell.magnetic_conductivity;
    se_r   <= in_cell.electric_conductivity;
    last_r <= {last_r[LAT-1:0], in_cell.last_cell};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-1:0], in_acc};
    end
  end

  // coefficient pipelines: pair 0 magnetic, pair 1 electric
  genvar p;
  generate
    for (p = 0; p < 2; p++) begin : g_pair
      flc_pkg::word_t med, sig;
      flc_pkg::word_t pw, qw, sw, rw, gw, denw, numw, decw, gainw;
      flc_pkg::word_t g_dly_r [flc_pkg::L_ADD];

      assign med = (p == 0) ? mu_r : eps_r;
      assign sig = (p == 0) ? sm_r : se_r;

      flc_fpu #(.OP(flc_pkg::FOP_MUL)) u_p (.clk(clk), .a(sig), .b(dt_r), .y(pw));
      flc_fpu #(.OP(flc_pkg::FOP_MUL)) u_q (.clk(clk), .a(med), .b(flc_pkg::FP_TWO), .y(qw));
      flc_fpu #(.OP(flc_pkg::FOP_MUL)) u_s (.clk(clk), .a(med), .b(dx_r), .y(sw));

      flc_fpu #(.OP(flc_pkg::FOP_DIV)) u_r (.clk(clk), .a(pw), .b(qw), .y(rw));
      flc_fpu #(.OP(flc_pkg::FOP_DIV)) u_g (.clk(clk), .a(dt_r), .b(sw), .y(gw));

      flc_fpu #(.OP(flc_pkg::FOP_ADD)) u_den (
        .clk(clk), .a(flc_pkg::FP_ONE), .b(rw), .y(denw)
      );
      flc_fpu #(.OP(flc_pkg::FOP_ADD)) u_num (
        .clk(clk), .a(flc_pkg::FP_ONE), .b({~rw[31], rw[30:0]}), .y(numw)
      );

      // g waits for the denominator
      always_ff @(posedge clk) begin
        g_dly_r[0] <= gw;
        for (int k = 1; k < flc_pkg::L_ADD; k++) begin
          g_dly_r[k] <= g_dly_r[k-1];
        end
      end

      flc_fpu #(.OP(flc_pkg::FOP_DIV)) u_dec (.clk(clk), .a(numw), .b(denw), .y(decw));
      flc_fpu #(.OP(flc_pkg::FOP_DIV)) u_gain (
        .clk(clk), .a(g_dly_r[flc_pkg::L_ADD-1]), .b(denw), .y(gainw)
      );

      assign dec_w[p]  = decw;
      assign gain_w[p] = gainw;
    end
  endgenerate

  // output queue
  assign push    = vld_r[LAT];
  assign mem_cnt = wr_ptr_r - rd_ptr_r;
  assign pop     = (mem_cnt != '0) && (!out_vld_r || out_coef.ready);
  assign out_acc = out_vld_r && out_coef.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({in_acc, out_acc})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    if (pop) out_vld_nxt = 1'b1;
    else if (out_coef.ready) out_vld_nxt = 1'b0;
    else out_vld_nxt = out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r[FIFO_AW-1:0]] <= {dec_w[0], gain_w[0], dec_w[1], gain_w[1],
                                          last_r[LAT]};
    end
    if (pop) begin
      out_data_r <= fifo_mem[rd_ptr_r[FIFO_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_coef.valid       = out_vld_r;
  assign out_coef.h_decay     = out_data_r[OUT_W-1 -: flc_pkg::FLT_W];
  assign out_coef.h_curl_gain = out_data_r[OUT_W-1-flc_pkg::FLT_W -: flc_pkg::FLT_W];
  assign out_coef.e_decay     = out_data_r[OUT_W-1-2*flc_pkg::FLT_W -: flc_pkg::FLT_W];
  assign out_coef.e_curl_gain = out_data_r[OUT_W-1-3*flc_pkg::FLT_W -: flc_pkg::FLT_W];
  assign out_coef.last_result = out_data_r[0];

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT) else $error("item count above queue depth");

  a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (cnt_r != '0)) else $error("result shown with no item outstanding");

  a_mem_credit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_cnt <= cnt_r) else $error("queue holds more items than outstanding");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (mem_cnt != DEPTH_CNT)) else $error("finished item met a full queue");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_acc) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("item count missed an accepted item");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Testbench for fdtd_lossy_coefficient_unit: drives cell items, predicts the
// four lossy update coefficients bit for bit and checks every result item.
// Depends on flc_pkg, flc_cell_if, flc_coef_if, flc_cfg_if and the RTL top.
module tb_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic [flc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 4'd9;

  typedef struct packed {
    flc_pkg::word_t mu;
    flc_pkg::word_t eps;
    flc_pkg::word_t sig_m;
    flc_pkg::word_t sig_e;
    logic           last;
  } cell_t;

  typedef struct packed {
    flc_pkg::word_t h_decay;
    flc_pkg::word_t h_gain;
    flc_pkg::word_t e_decay;
    flc_pkg::word_t e_gain;
    logic           last;
  } coef_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   fail_count = 0;
  int   cells_sent = 0;
  int   coefs_checked = 0;
  int   cfg_writes = 0;
  int   send_idle_pct = 0;
  int   rx_stall_pct = 0;
  flc_pkg::word_t dt_reg = 32'h0000_0000;
  flc_pkg::word_t dx_reg = flc_pkg::FP_ONE;
  coef_t coef_due[$];

  flc_cell_if cell_ch();
  flc_coef_if coef_ch();
  flc_cfg_if  cfg_ch();

  fdtd_lossy_coefficient_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_cell(cell_ch), .out_coef(coef_ch), .cfg_wr(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // float32 pattern to double
  function automatic real to_real(input flc_pkg::word_t w);
    logic [63:0] d;
    logic [23:0] f;
    int          e;
    if (&w[30:23]) begin
      d = (w[22:0] != 0) ? 64'h7FF8_0000_0000_0000 : {w[31], 11'h7FF, 52'd0};
    end else if (w[30:0] == 0) begin
      d = {w[31], 63'd0};
    end else begin
      if (w[30:23] == 0) begin
        e = -126;
        f = {1'b0, w[22:0]};
        while (!f[23]) begin
          f = f << 1;
          e = e - 1;
        end
      end else begin
        e = int'(w[30:23]) - 127;
        f = {1'b1, w[22:0]};
      end
      d = {w[31], 11'(e + 1023), f[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  // double to float32 pattern, round to nearest even, NaN canonical
  function automatic flc_pkg::word_t to_single(input real x);
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] kept;
    logic [31:0] val;
    int          ex;
    int          base;
    int          sh;
    logic        rb;
    logic        sticky;
    b = $realtobits(x);
    if (b[62:52] == 11'h7FF) begin
      return (b[51:0] != 0) ? flc_pkg::CANON_NAN : {b[63], 8'hFF, 23'd0};
    end
    if (b[62:52] == 11'd0) return {b[63], 31'd0};
    ex = int'(b[62:52]) - 1023;
    if (ex > 127) return {b[63], 8'hFF, 23'd0};
    m = {11'd0, 1'b1, b[51:0]};
    if (ex >= -126) begin
      base = ex + 126;
      sh = 29;
    end else begin
      base = 0;
      sh = 29 + (-126 - ex);
      if (sh > 54) sh = 54;
    end
    kept = m >> sh;
    rb = m[sh-1];
    sticky = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
    if (rb && (sticky || kept[0])) kept = kept + 64'd1;
    val = (32'(base) << 23) + kept[31:0];
    if (val[30:23] == 8'hFF) return {b[63], 8'hFF, 23'd0};
    return {b[63], val[30:0]};
  endfunction

  function automatic flc_pkg::word_t fmul(input flc_pkg::word_t a, input flc_pkg::word_t c);
    return to_single(to_real(a) * to_real(c));
  endfunction

  function automatic flc_pkg::word_t fdiv(input flc_pkg::word_t a, input flc_pkg::word_t c);
    return to_single(to_real(a) / to_real(c));
  endfunction

  function automatic flc_pkg::word_t fadd(input flc_pkg::word_t a, input flc_pkg::word_t c);
    return to_single(to_real(a) + to_real(c));
  endfunction

  function automatic flc_pkg::word_t fsub(input flc_pkg::word_t a, input flc_pkg::word_t c);
    return to_single(to_real(a) - to_real(c));
  endfunction

  function automatic void lossy_pair(input flc_pkg::word_t m, input flc_pkg::word_t sigma,
                                     output flc_pkg::word_t decay,
                                     output flc_pkg::word_t gain);
    flc_pkg::word_t r;
    flc_pkg::word_t den;
    r = fdiv(fmul(sigma, dt_reg), fmul(flc_pkg::FP_TWO, m));
    den = fadd(flc_pkg::FP_ONE, r);
    decay = fdiv(fsub(flc_pkg::FP_ONE, r), den);
    gain = fdiv(fdiv(dt_reg, fmul(m, dx_reg)), den);
  endfunction

  function automatic coef_t predict_coefs(input cell_t c);
    coef_t o;
    lossy_pair(c.mu, c.sig_m, o.h_decay, o.h_gain);
    lossy_pair(c.eps, c.sig_e, o.e_decay, o.e_gain);
    o.last = c.last;
    return o;
  endfunction

  function automatic flc_pkg::word_t plausible(input int elo, input int ehi);
    return {1'b0, 8'($urandom_range(ehi, elo)), 23'($urandom)};
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    if ($urandom_range(99) < 80) begin
      c.mu = plausible(100, 140);
      c.eps = plausible(95, 135);
      c.sig_m = ($urandom_range(9) == 0) ? 32'd0 : plausible(90, 150);
      c.sig_e = ($urandom_range(9) == 0) ? 32'd0 : plausible(90, 150);
    end else begin
      c.mu = $urandom;
      c.eps = $urandom;
      c.sig_m = $urandom;
      c.sig_e = $urandom;
    end
    c.last = ($urandom_range(15) == 0);
    return c;
  endfunction

  initial begin
    cell_ch.valid = 1'b0;
    cell_ch.permeability = '0;
    cell_ch.permittivity = '0;
    cell_ch.magnetic_conductivity = '0;
    cell_ch.electric_conductivity = '0;
    cell_ch.last_cell = 1'b0;
    coef_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = flc_pkg::REG_TIME_STEP;
    cfg_ch.data = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk)
    coef_ch.ready <= rst_n && ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk) begin
    coef_t got;
    coef_t want;
    if (rst_n && coef_ch.valid && coef_ch.ready) begin
      got = {coef_ch.h_decay, coef_ch.h_curl_gain, coef_ch.e_decay, coef_ch.e_curl_gain,
             coef_ch.last_result};
      if (coef_due.size() == 0) begin
        $error("coefficient item with none expected");
        fail_count++;
      end else begin
        want = coef_due.pop_front();
        coefs_checked++;
        if (got.h_decay !== want.h_decay) begin
          $error("h_decay expected %h got %h", want.h_decay, got.h_decay);
          fail_count++;
        end
        if (got.h_gain !== want.h_gain) begin
          $error("h_curl_gain expected %h got %h", want.h_gain, got.h_gain);
          fail_count++;
        end
        if (got.e_decay !== want.e_decay) begin
          $error("e_decay expected %h got %h", want.e_decay, got.e_decay);
          fail_count++;
        end
        if (got.e_gain !== want.e_gain) begin
          $error("e_curl_gain expected %h got %h", want.e_gain, got.e_gain);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last_result expected %b got %b", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  task automatic send_cell(input cell_t c);
    coef_t want;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cell_ch.valid <= 1'b0;
      @(posedge clk);
    end
    want = predict_coefs(c);
    cell_ch.valid <= 1'b1;
    cell_ch.permeability <= c.mu;
    cell_ch.permittivity <= c.eps;
    cell_ch.magnetic_conductivity <= c.sig_m;
    cell_ch.electric_conductivity <= c.sig_e;
    cell_ch.last_cell <= c.last;
    do @(posedge clk); while (!cell_ch.ready);
    coef_due.push_back(want);
    cells_sent++;
  endtask

  task automatic drain();
    cell_ch.valid <= 1'b0;
    while (coef_due.size() != 0) @(posedge clk);
    repeat (flc_pkg::LAT + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [flc_pkg::CFG_IDX_W-1:0] idx,
                           input flc_pkg::word_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == flc_pkg::REG_TIME_STEP) dt_reg = val;
    else if (idx == flc_pkg::REG_CELL_SIZE) dx_reg = val;
    cfg_writes++;
  endtask

  task automatic test_reset_defaults();
    repeat (4) send_cell(random_cell());
    drain();
  endtask

  task automatic test_special_cells();
    flc_pkg::word_t specials[14] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                     32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF,
                                     32'h0000_0001, 32'h007F_FFFF, 32'h7F7F_FFFF,
                                     32'h3F80_0000, 32'hBF80_0000, 32'h3586_A000,
                                     32'h2E00_0000, 32'h4000_0000};
    cell_t c;
    write_reg(flc_pkg::REG_TIME_STEP, 32'h3000_0000);
    write_reg(flc_pkg::REG_CELL_SIZE, 32'h3C23_D70A);
    foreach (specials[i]) begin
      c.mu = specials[i];
      c.eps = specials[13 - i];
      c.sig_m = plausible(100, 130);
      c.sig_e = specials[(i + 5) % 14];
      c.last = i[0];
      send_cell(c);
    end
    // lossless cell, a cell with sigma*dt = 2*mu so decay hits zero, and a huge-sigma cell
    c = '{32'h3586_A000, 32'h3F80_0000, 32'h0, 32'h0, 1'b1};
    send_cell(c);
    c = '{32'h3F80_0000, 32'h3F80_0000, 32'h4F80_0000, 32'h4F80_0000, 1'b0};
    send_cell(c);
    c = '{32'h3F80_0000, 32'h3F80_0000, 32'h7F00_0000, 32'h6000_0000, 1'b1};
    send_cell(c);
    drain();
  endtask

  task automatic test_register_extremes();
    flc_pkg::word_t dts[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h0000_0001,
                               32'h7F7F_FFFF, 32'h2B8C_BCCC};
    flc_pkg::word_t dxs[6] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h7F7F_FFFF,
                               32'hFF80_0000, 32'h3A83_126F};
    foreach (dts[i]) begin
      write_reg(flc_pkg::REG_TIME_STEP, dts[i]);
      write_reg(flc_pkg::REG_CELL_SIZE, dxs[i]);
      repeat (12) send_cell(random_cell());
      drain();
    end
    // unmapped index must leave both registers untouched
    write_reg(REG_UNMAPPED, 32'h1234_5678);
    repeat (8) send_cell(random_cell());
    drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n);
    send_idle_pct = idle;
    rx_stall_pct = stall;
    write_reg(flc_pkg::REG_TIME_STEP, plausible(95, 125));
    write_reg(flc_pkg::REG_CELL_SIZE, plausible(110, 135));
    for (int i = 0; i < n; i++) begin
      send_cell(random_cell());
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_special_cells();
    test_register_extremes();
    test_random_phase(0, 0, 330);
    test_random_phase(45, 0, 330);
    test_random_phase(0, 45, 330);
    test_random_phase(34, 34, 330);
    send_idle_pct = 0;
    rx_stall_pct = 0;
    $display("Covered %0d cells, %0d coefficient items checked, %0d register writes,",
             cells_sent, coefs_checked, cfg_writes);
    $display("special floats, register extremes and four sender/receiver stall mixes.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
